// ----- sv/prts_pkg.sv -----
`default_nettype none

package prts_pkg;

    localparam int LEVEL_BOUND    = 32;
    localparam int COEF_FRAC_BITS = 16;

    localparam int LEVEL_W = 6;
    localparam int WATT_W  = 16;
    localparam int CAD_W   = 16;

    // highest level the scan may reach
    localparam int TOP_LIMIT = (LEVEL_BOUND < 63) ? LEVEL_BOUND : 63;

    // multiplier: A carries cadence or cadence squared, B a coefficient or cadence
    localparam int MA_W   = 2 * CAD_W + 1;
    localparam int MB_W   = (COEF_FRAC_BITS + 2 > CAD_W + 1) ? COEF_FRAC_BITS + 2 : CAD_W + 1;
    localparam int PROD_W = MA_W + MB_W;

    // model sum is in Q(F+16); wattage starts at bit F+16
    localparam int WATT_LSB = COEF_FRAC_BITS + 16;
    localparam int SAT_LSB  = WATT_LSB + WATT_W;
    localparam int ACC_W    = COEF_FRAC_BITS + 34;

    localparam longint E8 = 64'sd100000000;

    typedef logic        [LEVEL_W-1:0] level_t;
    typedef logic        [WATT_W-1:0]  watt_t;
    typedef logic        [CAD_W-1:0]   cad_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [MB_W-1:0]    coef_t;

    // decimal coefficient scaled by 1e8, rounded half away from zero to Q(F)
    function automatic longint to_q(input longint dec_e8);
        longint mag;
        longint q;
        mag = (dec_e8 < 0) ? -dec_e8 : dec_e8;
        q   = ((mag <<< COEF_FRAC_BITS) + E8 / 2) / E8;
        return (dec_e8 < 0) ? -q : q;
    endfunction

    localparam longint K0 = to_q(64'sd1216860795);
    localparam longint K1 = to_q(64'sd12260211);
    localparam longint K2 = to_q(-64'sd39240546);
    localparam longint K3 = to_q(64'sd464781);
    localparam longint K4 = to_q(64'sd34516268);
    localparam longint K5 = to_q(-64'sd1031992);

    localparam coef_t K1_C = MB_W'(K1);
    localparam coef_t K3_C = MB_W'(K3);
    localparam coef_t K4_C = MB_W'(K4);

    // constant part of S(1) and of the first difference S(2)-S(1)
    localparam acc_t S1_BASE = ACC_W'((K0 + K2 + K5) <<< 16);
    localparam acc_t D1_BASE = ACC_W'((K2 + 3 * K5) <<< 16);
    localparam acc_t D_INC   = ACC_W'((2 * K5) <<< 16);

    localparam level_t LEVEL_MIN = LEVEL_W'(1);
    localparam level_t LEVEL_RST = LEVEL_W'(25);
    localparam level_t LEVEL_TOP = LEVEL_W'(TOP_LIMIT);

    typedef logic [3:0] upc_t;

    localparam upc_t UPC_WAIT   = 4'd0;
    localparam upc_t UPC_SQUARE = 4'd1;
    localparam upc_t UPC_LIN    = 4'd2;
    localparam upc_t UPC_CROSS  = 4'd3;
    localparam upc_t UPC_QUAD   = 4'd4;
    localparam upc_t UPC_SUM    = 4'd5;
    localparam upc_t UPC_FIRST  = 4'd6;
    localparam upc_t UPC_SCAN   = 4'd7;
    localparam upc_t UPC_PICK   = 4'd8;
    localparam upc_t UPC_FIN    = 4'd9;

    typedef enum logic [0:0] {MA_CAD, MA_SQ} mul_a_t;
    typedef enum logic [1:0] {MB_CAD, MB_K1, MB_K3, MB_K4} mul_b_t;
    typedef enum logic [2:0] {ACC_HOLD, ACC_INIT, ACC_ADD_P8, ACC_ADD_P, ACC_STEP} acc_op_t;
    typedef enum logic [1:0] {D_HOLD, D_INIT, D_ADD_P8, D_STEP} d_op_t;
    typedef enum logic [2:0] {LV_HOLD, LV_ONE, LV_START, LV_SCAN, LV_FALLBACK} lv_op_t;
    typedef enum logic [2:0] {
        COND_NEVER, COND_NO_INPUT, COND_CAD_ZERO, COND_TOP_ONE, COND_SCAN_CONT, COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic    in_rdy;
        mul_a_t  ma;
        mul_b_t  mb;
        acc_op_t acc_op;
        d_op_t   d_op;
        logic    sq_ld;
        lv_op_t  lv_op;
        logic    out_ld;
        cond_t   cond;
        upc_t    jmp;
        upc_t    nxt;
    } ctrl_t;

    typedef struct packed {
        logic cad_zero;
        logic top_one;
        logic scan_cont;
        logic out_busy;
    } status_t;

    localparam ctrl_t CTRL_NOP = '{
        in_rdy: 1'b0, ma: MA_CAD, mb: MB_CAD, acc_op: ACC_HOLD, d_op: D_HOLD,
        sq_ld: 1'b0, lv_op: LV_HOLD, out_ld: 1'b0, cond: COND_NEVER,
        jmp: UPC_WAIT, nxt: UPC_WAIT
    };

endpackage

`default_nettype wire

// ----- sv/prts_sequencer.sv -----
`default_nettype none

module prts_sequencer
    import prts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    upc_t pc_reg;
    upc_t pc_next;
    logic take_jump;

    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t w;
        w = CTRL_NOP;
        case (pc)
            UPC_WAIT:
            begin
                w.in_rdy = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.jmp    = UPC_WAIT;
                w.nxt    = UPC_SQUARE;
            end
            UPC_SQUARE:
            begin
                w.ma     = MA_CAD;
                w.mb     = MB_CAD;
                w.acc_op = ACC_INIT;
                w.d_op   = D_INIT;
                w.lv_op  = LV_ONE;
                w.cond   = COND_CAD_ZERO;
                w.jmp    = UPC_FIN;
                w.nxt    = UPC_LIN;
            end
            UPC_LIN:
            begin
                w.sq_ld = 1'b1;
                w.ma    = MA_CAD;
                w.mb    = MB_K1;
                w.nxt   = UPC_CROSS;
            end
            UPC_CROSS:
            begin
                w.acc_op = ACC_ADD_P8;
                w.ma     = MA_CAD;
                w.mb     = MB_K4;
                w.nxt    = UPC_QUAD;
            end
            UPC_QUAD:
            begin
                w.acc_op = ACC_ADD_P8;
                w.d_op   = D_ADD_P8;
                w.ma     = MA_SQ;
                w.mb     = MB_K3;
                w.nxt    = UPC_SUM;
            end
            UPC_SUM:
            begin
                w.acc_op = ACC_ADD_P;
                w.nxt    = UPC_FIRST;
            end
            UPC_FIRST:
            begin
                w.lv_op  = LV_START;
                w.acc_op = ACC_STEP;
                w.d_op   = D_STEP;
                w.cond   = COND_TOP_ONE;
                w.jmp    = UPC_PICK;
                w.nxt    = UPC_SCAN;
            end
            UPC_SCAN:
            begin
                w.lv_op  = LV_SCAN;
                w.acc_op = ACC_STEP;
                w.d_op   = D_STEP;
                w.cond   = COND_SCAN_CONT;
                w.jmp    = UPC_SCAN;
                w.nxt    = UPC_PICK;
            end
            UPC_PICK:
            begin
                w.lv_op = LV_FALLBACK;
                w.nxt   = UPC_FIN;
            end
            UPC_FIN:
            begin
                w.out_ld = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.jmp    = UPC_FIN;
                w.nxt    = UPC_WAIT;
            end
            default:
            begin
                w.nxt = UPC_WAIT;
            end
        endcase
        return w;
    endfunction

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NO_INPUT:  take_jump = !in_valid;
            COND_CAD_ZERO:  take_jump = status.cad_zero;
            COND_TOP_ONE:   take_jump = status.top_one;
            COND_SCAN_CONT: take_jump = status.scan_cont;
            COND_OUT_BUSY:  take_jump = status.out_busy;
            default:        take_jump = 1'b0;
        endcase
        pc_next = take_jump ? ctrl.jmp : ctrl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UPC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/prts_datapath.sv -----
`default_nettype none

module prts_datapath
    import prts_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire ctrl_t  ctrl,
    input  wire logic   in_take,
    input  wire watt_t  target_power,
    input  wire cad_t   cadence_avg,
    input  wire logic   cfg_we,
    input  wire level_t cfg_data,
    input  wire logic   out_ready,
    output status_t     status,
    output logic        out_valid,
    output level_t      resistance_level
);

    level_t max_level_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    level_t out_level_reg;

    watt_t  target_reg;
    cad_t   cad_reg;
    logic [2*CAD_W-1:0] sq_reg;
    logic signed [PROD_W-1:0] prod_reg;
    acc_t   acc_reg;
    acc_t   acc_next;
    acc_t   d_reg;
    acc_t   d_next;
    watt_t  w1_reg;
    watt_t  wprev_reg;
    level_t r_reg;
    level_t level_reg;
    logic   found_reg;

    logic signed [MA_W-1:0] mul_a;
    coef_t  mul_b;
    acc_t   prod_ext;
    watt_t  wcur;
    level_t top;
    logic   match;
    logic   out_load;

    // clamp the register to 1 .. TOP_LIMIT
    always_comb
    begin
        if (max_level_reg == '0)
            top = LEVEL_MIN;
        else if (max_level_reg > LEVEL_TOP)
            top = LEVEL_TOP;
        else
            top = max_level_reg;
    end

    always_comb
    begin
        case (ctrl.ma)
            MA_SQ:   mul_a = $signed({1'b0, sq_reg});
            default: mul_a = $signed({(CAD_W + 1)'(0), cad_reg});
        endcase
        case (ctrl.mb)
            MB_K1:   mul_b = K1_C;
            MB_K3:   mul_b = K3_C;
            MB_K4:   mul_b = K4_C;
            default: mul_b = $signed(MB_W'(cad_reg));
        endcase
    end

    assign prod_ext = acc_t'(prod_reg);

    // saturate the running sum to 0..65535 watts
    always_comb
    begin
        if (acc_reg[ACC_W-1])
            wcur = '0;
        else if (|acc_reg[ACC_W-2:SAT_LSB])
            wcur = '1;
        else
            wcur = acc_reg[SAT_LSB-1:WATT_LSB];
    end

    assign match = (wprev_reg <= target_reg) && (wcur >= target_reg);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_INIT:   acc_next = S1_BASE;
            ACC_ADD_P8: acc_next = acc_reg + (prod_ext <<< 8);
            ACC_ADD_P:  acc_next = acc_reg + prod_ext;
            ACC_STEP:   acc_next = acc_reg + d_reg;
            default:    acc_next = acc_reg;
        endcase
        case (ctrl.d_op)
            D_INIT:   d_next = D1_BASE;
            D_ADD_P8: d_next = d_reg + (prod_ext <<< 8);
            D_STEP:   d_next = d_reg + D_INC;
            default:  d_next = d_reg;
        endcase
    end

    assign status.cad_zero  = (cad_reg == '0);
    assign status.top_one   = (top == LEVEL_MIN);
    assign status.scan_cont = !match && ((r_reg + LEVEL_MIN) < top);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_load = ctrl.out_ld && !status.out_busy;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= LEVEL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_level_reg <= cfg_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            target_reg <= target_power;
            cad_reg    <= cadence_avg;
        end
        prod_reg <= mul_a * mul_b;
        if (ctrl.sq_ld)
            sq_reg <= prod_reg[2*CAD_W-1:0];
        acc_reg <= acc_next;
        d_reg   <= d_next;
        case (ctrl.lv_op)
            LV_ONE:
            begin
                level_reg <= LEVEL_MIN;
            end
            LV_START:
            begin
                w1_reg    <= wcur;
                wprev_reg <= wcur;
                r_reg     <= LEVEL_MIN;
                found_reg <= 1'b0;
            end
            LV_SCAN:
            begin
                // wcur holds the wattage of the level above r here
                if (match)
                    level_reg <= r_reg;
                found_reg <= match;
                wprev_reg <= wcur;
                r_reg     <= r_reg + LEVEL_MIN;
            end
            LV_FALLBACK:
            begin
                if (!found_reg)
                    level_reg <= (target_reg < w1_reg) ? LEVEL_MIN : top;
            end
            default:
            begin
            end
        endcase
        if (out_load)
            out_level_reg <= level_reg;
    end

    assign out_valid        = out_valid_reg;
    assign resistance_level = out_level_reg;

endmodule

`default_nettype wire

// ----- sv/power_to_resistance_search.sv -----
`default_nettype none

// Picks the brake resistance level whose modelled wattage brackets the requested
// power at the given Q8.8 cadence, from level 1 up to the max_level register
// (reset 25; it is to be written through the cfg channel only while idle, a rule
// for the user that the block does not enforce). A short step table drives one
// shared multiplier for the cadence terms, then the scan walks the levels one per
// cycle by forward differences, over no level with a top level of 1, else over
// levels 1 .. top level - 1; at zero cadence it is skipped. The next word is
// accepted in the cycle after the result is loaded into the output register. A
// finished word waits in the output register while the next word is accepted
// and computed; if it is still unread when the next result is ready, the block
// holds in its last step.
module power_to_resistance_search
    import prts_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_valid,
    output logic        cfg_ready,
    input  wire level_t cfg_data,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire watt_t  target_power,
    input  wire cad_t   cadence_avg,
    output logic        out_valid,
    input  wire logic   out_ready,
    output level_t      resistance_level
);

    ctrl_t   ctrl;
    status_t status;
    logic    in_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = ctrl.in_rdy;
    assign in_take   = in_valid && ctrl.in_rdy;

    prts_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    prts_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .in_take          (in_take),
        .target_power     (target_power),
        .cadence_avg      (cadence_avg),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .out_ready        (out_ready),
        .status           (status),
        .out_valid        (out_valid),
        .resistance_level (resistance_level)
    );

endmodule

`default_nettype wire
